// ===== src/psa_pkg.sv =====
// Shared widths, payload types, cell token types and helpers of the priority scheduler.
package psa_pkg;

	localparam int MAX_PROC = 16;
	localparam int IDX_W    = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
	localparam int CNT_W    = $clog2(MAX_PROC + 1);

	localparam int TIME_W   = 16;
	localparam int PRI_IN_W = 10;
	localparam int PRI_W    = 11;
	localparam int ID_W     = 5;
	localparam int CLK_W    = 21;
	localparam int SUM_W    = 25;

	localparam logic [PRI_W-1:0] PRI_MAX   = '1;
	localparam logic [1:0]       AGE_PICK  = 2'd1;
	localparam logic [1:0]       AGE_OTHER = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]   arrival_time;
		logic [TIME_W-1:0]   service_time;
		logic [PRI_IN_W-1:0] start_priority;
		logic                last_job;
	} job_t;

	typedef struct packed {
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] job_arrival;
		logic [TIME_W-1:0] job_service;
		logic [PRI_W-1:0]  aged_priority;
		logic [CLK_W-1:0]  completion_time;
		logic [CLK_W-1:0]  waiting_time;
		logic [CLK_W-1:0]  turnaround_time;
		logic [SUM_W-1:0]  total_waiting;
		logic [SUM_W-1:0]  total_turnaround;
		logic              last_result;
	} res_t;

	// One candidate job carried along the cell row.
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  id;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] svc;
		logic [PRI_W-1:0]  pri;
	} cand_t;

	// Scan token: best ready job, and best job among the earliest arrivals.
	typedef struct packed {
		logic  live;
		cand_t rdy;
		cand_t mn;
	} tok_t;

	// Controls broadcast from the controller to every cell.
	typedef struct packed {
		logic                load;
		logic [IDX_W-1:0]    load_idx;
		logic [TIME_W-1:0]   arr;
		logic [TIME_W-1:0]   svc;
		logic [PRI_IN_W-1:0] pri;
		logic                clear;
		logic                commit;
		logic [IDX_W-1:0]    pick;
		logic [CLK_W-1:0]    clock;
	} bcast_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_FIN,
		ST_OUT
	} state_t;

	function automatic logic [PRI_W-1:0] age_add(input logic [PRI_W-1:0] p,
			input logic [1:0] d);
		logic [PRI_W:0] s;
		s = {1'b0, p} + {{(PRI_W-1){1'b0}}, d};
		return s[PRI_W] ? PRI_MAX : s[PRI_W-1:0];
	endfunction

endpackage

// ===== src/psa_if.sv =====
// Valid/ready channel interfaces for job items and result items.
interface psa_job_if;
	import psa_pkg::*;
	logic valid;
	logic ready;
	job_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface psa_res_if;
	import psa_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/psa_cell.sv =====
// One job slot of the scheduler row: holds a job, ages it and refines the passing scan token.
module psa_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [psa_pkg::IDX_W-1:0] idx,
	input  psa_pkg::bcast_t        bc,
	input  psa_pkg::tok_t          tin,
	output psa_pkg::tok_t          tout
);
	import psa_pkg::*;

	logic              valid_q;
	logic              done_q;
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] svc_q;
	logic [PRI_W-1:0]  pri_q;
	logic              live_q;
	cand_t             rdy_q;
	cand_t             mn_q;

	logic  active;
	logic  is_ready;
	logic  take_rdy;
	logic  take_mn;
	logic  hit_load;
	logic  is_pick;
	cand_t mine;

	assign active   = valid_q && !done_q;
	assign is_ready = active && (CLK_W'(arr_q) <= bc.clock);
	assign hit_load = bc.load && (bc.load_idx == idx);
	assign is_pick  = (bc.pick == idx);

	// Strict comparisons keep the earlier cell on a full tie, which is the lower id.
	assign take_rdy = is_ready && (!tin.rdy.found || (pri_q > tin.rdy.pri) ||
		((pri_q == tin.rdy.pri) && (arr_q < tin.rdy.arr)));
	assign take_mn  = active && (!tin.mn.found || (arr_q < tin.mn.arr) ||
		((arr_q == tin.mn.arr) && (pri_q > tin.mn.pri)));

	always_comb begin
		mine.found = 1'b1;
		mine.id    = idx;
		mine.arr   = arr_q;
		mine.svc   = svc_q;
		mine.pri   = pri_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			live_q  <= 1'b0;
		end else begin
			live_q <= tin.live;
			if (bc.clear) begin
				valid_q <= 1'b0;
				done_q  <= 1'b0;
			end else if (hit_load) begin
				valid_q <= 1'b1;
				done_q  <= 1'b0;
			end else if (bc.commit && active && is_pick) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_load) begin
			arr_q <= bc.arr;
			svc_q <= bc.svc;
			pri_q <= PRI_W'(bc.pri);
		end else if (bc.commit && active) begin
			pri_q <= age_add(pri_q, is_pick ? AGE_PICK : AGE_OTHER);
		end
		rdy_q <= take_rdy ? mine : tin.rdy;
		mn_q  <= take_mn ? mine : tin.mn;
	end

	always_comb begin
		tout.live = live_q;
		tout.rdy  = rdy_q;
		tout.mn   = mn_q;
	end

endmodule

// ===== src/psa_ctrl.sv =====
// Scheduler controller: loads jobs into the row, launches scans and forms each result.
module psa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	psa_job_if.sink         job,
	psa_res_if.source       res,
	input  psa_pkg::tok_t   tail,
	output psa_pkg::tok_t   head,
	output psa_pkg::bcast_t bc
);
	import psa_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  left_q;
	logic [CLK_W-1:0]  clock_q;
	logic [IDX_W-1:0]  pick_q;
	logic [TIME_W-1:0] parr_q;
	logic [TIME_W-1:0] psvc_q;
	logic [PRI_W-1:0]  ppri_q;
	logic [CLK_W-1:0]  turn_q;
	logic [CLK_W-1:0]  wait_q;
	logic [SUM_W-1:0]  wsum_q;
	logic [SUM_W-1:0]  tsum_q;
	logic              head_live_q;
	logic              res_valid_q;
	res_t              res_q;

	logic             full;
	logic             last;
	logic             inject;
	logic             res_load;
	cand_t            chosen;
	logic [CLK_W-1:0] base;
	logic [SUM_W-1:0] wsum_nx;
	logic [SUM_W-1:0] tsum_nx;

	assign full    = (count_q == CNT_W'(MAX_PROC));
	assign last    = (left_q == CNT_W'(1));
	// With nothing ready the clock jumps to the earliest pending arrival.
	assign chosen  = tail.rdy.found ? tail.rdy : tail.mn;
	assign base    = tail.rdy.found ? clock_q : CLK_W'(tail.mn.arr);
	assign wsum_nx = wsum_q + SUM_W'(wait_q);
	assign tsum_nx = tsum_q + SUM_W'(turn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		job.ready   = 1'b0;
		inject      = 1'b0;
		res_load    = 1'b0;
		bc.load     = 1'b0;
		bc.load_idx = count_q[IDX_W-1:0];
		bc.arr      = job.data.arrival_time;
		bc.svc      = job.data.service_time;
		bc.pri      = job.data.start_priority;
		bc.clear    = 1'b0;
		bc.commit   = 1'b0;
		bc.pick     = pick_q;
		bc.clock    = clock_q;
		case (state_q)
			ST_LOAD: begin
				job.ready = 1'b1;
				if (job.valid) begin
					bc.load = !full;
					if (job.data.last_job) begin
						inject  = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (tail.live) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_valid_q || res.ready) begin
					res_load  = 1'b1;
					bc.commit = 1'b1;
					if (last) begin
						bc.clear = 1'b1;
						state_d  = ST_LOAD;
					end else begin
						inject  = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			head_live_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			head_live_q <= inject;
			if (bc.load) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_LOAD && job.valid && job.data.last_job) begin
				left_q <= full ? count_q : count_q + CNT_W'(1);
			end else if (res_load) begin
				left_q <= left_q - CNT_W'(1);
			end
			if (bc.clear) begin
				count_q <= '0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && job.valid && job.data.last_job) begin
			clock_q <= '0;
			wsum_q  <= '0;
			tsum_q  <= '0;
		end
		if (state_q == ST_SCAN && tail.live) begin
			clock_q <= base + CLK_W'(chosen.svc);
			pick_q  <= chosen.id;
			parr_q  <= chosen.arr;
			psvc_q  <= chosen.svc;
			ppri_q  <= age_add(chosen.pri, AGE_PICK);
		end
		if (state_q == ST_FIN) begin
			turn_q <= clock_q - CLK_W'(parr_q);
			wait_q <= clock_q - CLK_W'(parr_q) - CLK_W'(psvc_q);
		end
		if (res_load) begin
			wsum_q                 <= wsum_nx;
			tsum_q                 <= tsum_nx;
			res_q.job_id           <= ID_W'({1'b0, pick_q} + {{IDX_W{1'b0}}, 1'b1});
			res_q.job_arrival      <= parr_q;
			res_q.job_service      <= psvc_q;
			res_q.aged_priority    <= ppri_q;
			res_q.completion_time  <= clock_q;
			res_q.waiting_time     <= wait_q;
			res_q.turnaround_time  <= turn_q;
			res_q.total_waiting    <= wsum_nx;
			res_q.total_turnaround <= tsum_nx;
			res_q.last_result      <= last;
		end
	end

	always_comb begin
		head.live = head_live_q;
		head.rdy  = '0;
		head.mn   = '0;
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

// ===== src/priority_scheduler_with_aging_core.sv =====
// Top level of the non-preemptive priority scheduler with aging.
// Jobs are taken one per cycle while loading and numbered from 1; the job marked last_job
// closes the set and starts scheduling, and one result per stored job follows in dispatch
// order. Each dispatch sends a scan token down the row of MAX_PROC job cells, one cell
// per cycle, then registers the pick and the new clock, works out the waiting and
// turnaround times in ST_FIN and issues the result in ST_OUT once the result register
// is free. No job is taken while a set is being scheduled; the next set may load while
// the final result still waits to be taken.
module priority_scheduler_with_aging_core (
	input  logic      clk,
	input  logic      arst_n,
	psa_job_if.sink   job,
	psa_res_if.source res
);
	import psa_pkg::*;

	tok_t   tok [MAX_PROC+1];
	bcast_t bc;

	psa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.res    (res),
		.tail   (tok[MAX_PROC]),
		.head   (tok[0]),
		.bc     (bc)
	);

	for (genvar g = 0; g < MAX_PROC; g++) begin : g_cell
		psa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(g)),
			.bc     (bc),
			.tin    (tok[g]),
			.tout   (tok[g+1])
		);
	end

endmodule

// ===== src/psa_checker.sv =====
// Port-level checks of the priority scheduler and their binding to the top level.
module psa_checker (
	input logic       clk,
	input logic       arst_n,
	psa_job_if.sink   job,
	psa_res_if.source res
);
	import psa_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result changed or dropped while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid && job.ready && job.data.last_job |=> !job.ready)
		else $error("job taken while a set is being scheduled");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.data.job_id != '0)
		else $error("result with job id zero");

	a_time_relations: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |->
			(CLK_W'(res.data.job_service) + res.data.waiting_time
				== res.data.turnaround_time) &&
			(CLK_W'(res.data.job_arrival) + res.data.turnaround_time
				== res.data.completion_time))
		else $error("waiting, turnaround and completion times disagree");

endmodule

bind priority_scheduler_with_aging_core psa_checker u_psa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.job    (job),
	.res    (res)
);
